>>> rtl/fwem_pkg.sv
// Package for the sliding-window edit distance matcher.
// Holds the sizes, command and register codes and the shared types.
// No dependencies; every other file imports it.
package fwem_pkg;

    localparam int PATTERN_MAX   = 32;
    localparam int IDX_W         = $clog2(PATTERN_MAX);
    localparam int LEN_W         = $clog2(PATTERN_MAX + 1);
    localparam int DIST_W        = LEN_W;
    localparam int CHAR_BITS     = 16;
    localparam int POSITION_BITS = 24;
    localparam int LIMIT_W       = 16;
    localparam int APB_AW        = 3;
    localparam int APB_DW        = 32;
    localparam int S_DATA_W      = 16;
    localparam int S_USER_W      = 2;
    localparam int M_DATA_W      = 80;
    localparam int M_USER_W      = 1;

    localparam logic [POSITION_BITS-1:0] POS_MAX      = {POSITION_BITS{1'b1}};
    localparam logic [CHAR_BITS-1:0]     NEWLINE_UNIT = CHAR_BITS'(10);
    localparam logic [DIST_W-1:0]        MAX_DIST_RST = DIST_W'(2);
    localparam logic [LIMIT_W-1:0]       LIMIT_RST    = LIMIT_W'(100);

    typedef enum logic [1:0] {
        CMD_NEW_SEARCH = 2'd0,
        CMD_PATTERN    = 2'd1,
        CMD_DOCUMENT   = 2'd2,
        CMD_TEXT       = 2'd3
    } cmd_t;

    typedef enum logic {
        REG_MAX_DISTANCE = 1'b0,
        REG_RESULT_LIMIT = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CALC = 3'b010,
        S_FIN  = 3'b100
    } state_t;

    typedef struct packed {
        logic [CHAR_BITS-1:0]     char_unit;
        logic [POSITION_BITS-1:0] line;
        logic [POSITION_BITS-1:0] column;
    } win_entry_t;

    typedef struct packed {
        logic [DIST_W-1:0] diag;
        logic [DIST_W-1:0] up;
        logic [DIST_W-1:0] left;
        logic              differ;
    } cell_in_t;

endpackage

>>> rtl/fwem_cell.sv
// Shared dynamic-programming cell: one Levenshtein cell per use.
// Takes the diagonal, upper and left neighbours and the mismatch flag.
// Depends on fwem_pkg.
module fwem_cell (
    input  fwem_pkg::cell_in_t            cell_in,
    output logic [fwem_pkg::DIST_W-1:0]   best
);
    import fwem_pkg::*;

    logic [DIST_W-1:0] sub_cost;
    logic [DIST_W-1:0] del_cost;
    logic [DIST_W-1:0] ins_cost;
    logic [DIST_W-1:0] min_a;

    always_comb
    begin
        sub_cost = cell_in.diag + DIST_W'(cell_in.differ);
        del_cost = cell_in.up + DIST_W'(1);
        ins_cost = cell_in.left + DIST_W'(1);
        min_a    = (del_cost < sub_cost) ? del_cost : sub_cost;
        best     = (ins_cost < min_a) ? ins_cost : min_a;
    end

endmodule

>>> rtl/fwem_store.sv
// Pattern store and text window shift line with their read ports.
// The newest text unit enters at the top entry of the window.
// Depends on fwem_pkg.
module fwem_store (
    input  logic                            clk,
    input  logic                            pat_we,
    input  logic [fwem_pkg::IDX_W-1:0]      pat_waddr,
    input  logic [fwem_pkg::CHAR_BITS-1:0]  pat_wdata,
    input  logic                            win_shift,
    input  fwem_pkg::win_entry_t            win_in,
    input  logic [fwem_pkg::IDX_W-1:0]      pat_raddr,
    input  logic [fwem_pkg::IDX_W-1:0]      win_raddr,
    input  logic [fwem_pkg::IDX_W-1:0]      head_raddr,
    output logic [fwem_pkg::CHAR_BITS-1:0]  pat_rdata,
    output logic [fwem_pkg::CHAR_BITS-1:0]  win_rdata,
    output fwem_pkg::win_entry_t            head_rdata
);
    import fwem_pkg::*;

    logic [CHAR_BITS-1:0] pat_reg [PATTERN_MAX];
    win_entry_t           win_reg [PATTERN_MAX];

    always_ff @(posedge clk)
    begin
        if (pat_we)
        begin
            pat_reg[pat_waddr] <= pat_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (win_shift)
        begin
            for (int k = 0; k < PATTERN_MAX - 1; k++)
            begin
                win_reg[k] <= win_reg[k + 1];
            end
            win_reg[PATTERN_MAX - 1] <= win_in;
        end
    end

    assign pat_rdata  = pat_reg[pat_raddr];
    assign win_rdata  = win_reg[win_raddr].char_unit;
    assign head_rdata = win_reg[head_raddr];

endmodule

>>> rtl/fwem_apb.sv
// Configuration registers behind an APB-style port.
// Holds the distance tolerance and the per-search result limit.
// Depends on fwem_pkg.
module fwem_apb (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [fwem_pkg::APB_AW-1:0]    paddr,
    input  logic [fwem_pkg::APB_DW-1:0]    pwdata,
    output logic [fwem_pkg::APB_DW-1:0]    prdata,
    output logic                           pready,
    output logic [fwem_pkg::DIST_W-1:0]    max_distance,
    output logic [fwem_pkg::LIMIT_W-1:0]   result_limit
);
    import fwem_pkg::*;

    logic [DIST_W-1:0]  max_dist_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic               wr_en;
    reg_idx_t           reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_sel = reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_dist_reg <= MAX_DIST_RST;
            limit_reg    <= LIMIT_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_MAX_DISTANCE: max_dist_reg <= pwdata[DIST_W-1:0];
                REG_RESULT_LIMIT: limit_reg    <= pwdata[LIMIT_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_MAX_DISTANCE: prdata = APB_DW'(max_dist_reg);
            REG_RESULT_LIMIT: prdata = APB_DW'(limit_reg);
            default:          prdata = '0;
        endcase
    end

    assign max_distance = max_dist_reg;
    assign result_limit = limit_reg;

endmodule

>>> rtl/fuzzy_window_edit_distance_matcher_top.sv
// Sliding-window Levenshtein matcher: one shared cell steps through the DP table.
// A compared text word steps the shared cell through S_CALC and then the S_FIN step, which
// may wait on a full output register; other words are taken without leaving S_IDLE, the
// only state in which s_tready is high. Reset clears the counters and the pattern length,
// sets line and column to 1, max_distance to 2 and result_limit to 100.
// No clearing pass is needed. Depends on fwem_pkg and submodules.
module fuzzy_window_edit_distance_matcher_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [fwem_pkg::APB_AW-1:0]     paddr,
    input  logic [fwem_pkg::APB_DW-1:0]     pwdata,
    output logic [fwem_pkg::APB_DW-1:0]     prdata,
    output logic                            pready,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // char_value[15:0]
    input  logic [fwem_pkg::S_DATA_W-1:0]   s_tdata,
    // command[1:0]
    input  logic [fwem_pkg::S_USER_W-1:0]   s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // match_start[23:0], edit_distance[29:24], line_number[53:30],
    // column_number[77:54], zero fill[79:78]
    output logic [fwem_pkg::M_DATA_W-1:0]   m_tdata,
    // is_fuzzy[0]
    output logic [fwem_pkg::M_USER_W-1:0]   m_tuser
);
    import fwem_pkg::*;

    logic [DIST_W-1:0]        max_distance;
    logic [LIMIT_W-1:0]       result_limit;

    state_t                   state_reg, state_next;
    logic [LEN_W-1:0]         pat_len_reg, pat_len_next;
    logic [LEN_W-1:0]         seen_reg, seen_next;
    logic [LEN_W-1:0]         skip_reg, skip_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [POSITION_BITS-1:0] line_reg, line_next;
    logic [POSITION_BITS-1:0] col_reg, col_next;
    logic [LIMIT_W-1:0]       count_reg, count_next;
    logic [IDX_W-1:0]         i_reg, i_next;
    logic [IDX_W-1:0]         j_reg, j_next;
    logic [DIST_W-1:0]        diag_reg, diag_next;
    logic [DIST_W-1:0]        left_reg, left_next;
    logic [DIST_W-1:0]        dist_reg, dist_next;
    logic [POSITION_BITS-1:0] start_reg, start_next;
    logic [DIST_W-1:0]        row_reg [PATTERN_MAX];
    logic                     out_valid_reg, out_valid_next;
    logic [M_DATA_W-1:0]      out_data_reg, out_data_next;
    logic                     out_fuzzy_reg, out_fuzzy_next;

    logic                     accept;
    cmd_t                     cmd;
    logic [CHAR_BITS-1:0]     unit;
    logic                     pat_we;
    logic                     win_shift;
    win_entry_t               win_in;
    logic [IDX_W-1:0]         win_raddr;
    logic [IDX_W-1:0]         head_raddr;
    logic [CHAR_BITS-1:0]     pat_rdata;
    logic [CHAR_BITS-1:0]     win_rdata;
    win_entry_t               head_rdata;
    cell_in_t                 cell_in;
    logic [DIST_W-1:0]        best;
    logic                     row_we;
    logic [IDX_W-1:0]         last_idx;
    logic [POSITION_BITS-1:0] span;
    logic [POSITION_BITS-1:0] match_start;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid & s_tready;
    assign cmd      = cmd_t'(s_tuser);
    assign unit     = s_tdata[CHAR_BITS-1:0];
    assign last_idx = IDX_W'(pat_len_reg - LEN_W'(1));
    assign win_in   = '{char_unit: unit, line: line_reg, column: col_reg};

    assign win_raddr  = IDX_W'(LEN_W'(PATTERN_MAX) - pat_len_reg + LEN_W'(i_reg));
    assign head_raddr = IDX_W'(LEN_W'(PATTERN_MAX) - pat_len_reg);

    fwem_apb u_apb (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .max_distance (max_distance),
        .result_limit (result_limit)
    );

    fwem_store u_store (
        .clk        (clk),
        .pat_we     (pat_we),
        .pat_waddr  (IDX_W'(pat_len_reg)),
        .pat_wdata  (unit),
        .win_shift  (win_shift),
        .win_in     (win_in),
        .pat_raddr  (j_reg),
        .win_raddr  (win_raddr),
        .head_raddr (head_raddr),
        .pat_rdata  (pat_rdata),
        .win_rdata  (win_rdata),
        .head_rdata (head_rdata)
    );

    always_comb
    begin
        cell_in.diag   = diag_reg;
        cell_in.up     = (i_reg == '0) ? (LEN_W'(j_reg) + LEN_W'(1)) : row_reg[j_reg];
        cell_in.left   = left_reg;
        cell_in.differ = (win_rdata != pat_rdata);
    end

    fwem_cell u_cell (
        .cell_in (cell_in),
        .best    (best)
    );

    assign span        = POSITION_BITS'(last_idx);
    assign match_start = (start_reg >= span) ? (start_reg - span) : '0;

    always_comb
    begin
        state_next     = state_reg;
        pat_len_next   = pat_len_reg;
        seen_next      = seen_reg;
        skip_next      = skip_reg;
        pos_next       = pos_reg;
        line_next      = line_reg;
        col_next       = col_reg;
        count_next     = count_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        diag_next      = diag_reg;
        left_next      = left_reg;
        dist_next      = dist_reg;
        start_next     = start_reg;
        out_valid_next = out_valid_reg & ~m_tready;
        out_data_next  = out_data_reg;
        out_fuzzy_next = out_fuzzy_reg;
        pat_we         = 1'b0;
        win_shift      = 1'b0;
        row_we         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd) inside
                        CMD_NEW_SEARCH, CMD_DOCUMENT:
                        begin
                            if (cmd == CMD_NEW_SEARCH)
                            begin
                                pat_len_next = '0;
                                count_next   = '0;
                            end
                            seen_next = '0;
                            skip_next = '0;
                            pos_next  = '0;
                            line_next = POSITION_BITS'(1);
                            col_next  = POSITION_BITS'(1);
                        end
                        CMD_PATTERN:
                        begin
                            if (pat_len_reg < LEN_W'(PATTERN_MAX))
                            begin
                                pat_we       = 1'b1;
                                pat_len_next = pat_len_reg + LEN_W'(1);
                            end
                        end
                        default:
                        begin
                            win_shift  = 1'b1;
                            start_next = pos_reg;
                            if (seen_reg < LEN_W'(PATTERN_MAX))
                            begin
                                seen_next = seen_reg + LEN_W'(1);
                            end
                            pos_next = (pos_reg == POS_MAX) ? POS_MAX
                                                            : pos_reg + POSITION_BITS'(1);
                            if (unit == NEWLINE_UNIT)
                            begin
                                line_next = (line_reg == POS_MAX) ? POS_MAX
                                                                  : line_reg + POSITION_BITS'(1);
                                col_next  = POSITION_BITS'(1);
                            end
                            else
                            begin
                                col_next = (col_reg == POS_MAX) ? POS_MAX
                                                                : col_reg + POSITION_BITS'(1);
                            end
                            if ((pat_len_reg != '0) && (seen_next >= pat_len_reg))
                            begin
                                if (skip_reg != '0)
                                begin
                                    skip_next = skip_reg - LEN_W'(1);
                                end
                                else if (count_reg < result_limit)
                                begin
                                    state_next = S_CALC;
                                    i_next     = '0;
                                    j_next     = '0;
                                    diag_next  = '0;
                                    left_next  = DIST_W'(1);
                                end
                            end
                        end
                    endcase
                end
            end
            S_CALC:
            begin
                row_we = 1'b1;
                if (j_reg == last_idx)
                begin
                    if (i_reg == last_idx)
                    begin
                        dist_next  = best;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        i_next    = i_reg + IDX_W'(1);
                        j_next    = '0;
                        diag_next = DIST_W'(i_reg) + DIST_W'(1);
                        left_next = DIST_W'(i_reg) + DIST_W'(2);
                    end
                end
                else
                begin
                    j_next    = j_reg + IDX_W'(1);
                    diag_next = cell_in.up;
                    left_next = best;
                end
            end
            S_FIN:
            begin
                if (dist_reg > max_distance)
                begin
                    state_next = S_IDLE;
                end
                else if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {2'b00, head_rdata.column, head_rdata.line,
                                      dist_reg, match_start};
                    out_fuzzy_next = (dist_reg != '0);
                    skip_next      = LEN_W'(last_idx);
                    count_next     = count_reg + LIMIT_W'(1);
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pat_len_reg   <= '0;
            seen_reg      <= '0;
            skip_reg      <= '0;
            pos_reg       <= '0;
            line_reg      <= POSITION_BITS'(1);
            col_reg       <= POSITION_BITS'(1);
            count_reg     <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pat_len_reg   <= pat_len_next;
            seen_reg      <= seen_next;
            skip_reg      <= skip_next;
            pos_reg       <= pos_next;
            line_reg      <= line_next;
            col_reg       <= col_next;
            count_reg     <= count_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        diag_reg      <= diag_next;
        left_reg      <= left_next;
        dist_reg      <= dist_next;
        start_reg     <= start_next;
        out_data_reg  <= out_data_next;
        out_fuzzy_reg <= out_fuzzy_next;
        if (row_we)
        begin
            row_reg[j_reg] <= best;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_fuzzy_reg;

endmodule

>>> rtl/fwem_checker.sv
// Port-level checker for the matcher top level, attached by the bind below.
// Checks output hold, flag, range and timing vs input. Depends on fwem_pkg.
module fwem_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [fwem_pkg::M_DATA_W-1:0]   m_tdata,
    input  logic [fwem_pkg::M_USER_W-1:0]   m_tuser
);
    import fwem_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output word changed while stalled");

    a_fuzzy_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser[0] == (m_tdata[29:24] != '0)))
        else $error("fuzzy flag disagrees with distance");

    a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[29:24] <= 6'(PATTERN_MAX))
                     && (m_tdata[53:30] != '0) && (m_tdata[77:54] != '0))
        else $error("result word out of range");

    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tvalid && s_tready))
        else $error("result appeared straight after an accepted word");

endmodule

bind fuzzy_window_edit_distance_matcher_top fwem_checker u_fwem_checker (.*);
